// File: design/multi_queue_shared_buffer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-queue shared buffer
// Shared helpers for the concurrent checks in the RTL modules. Each macro
// expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH
`define MULTI_QUEUE_SHARED_BUFFER_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define MQSB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define MQSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg: shared types and constants
// Sizes, pointer types, request and status codes for the multi-queue
// shared buffer.
// ----------------------------------------------------------------------------
package mqsb_pkg;

  // Store and queue sizes
  localparam int NUM_SLOTS  = 16;
  localparam int NUM_QUEUES = 4;

  // Slot index and pointer widths; a pointer equal to NUM_SLOTS is null
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int PTR_W  = $clog2(NUM_SLOTS + 1);
  localparam int QID_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // Field widths on the ports
  localparam int QUEUE_ID_W = 2;
  localparam int DATA_W     = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 32;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [QID_W-1:0]  qid_t;

  localparam ptr_t NULL_PTR = PTR_W'(NUM_SLOTS);

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // Outcome of one request, from the link manager to the data side
  typedef struct packed {
    status_t status;
    logic    data_we;
    logic    data_rd;
    slot_t   slot;
  } op_res_t;

  // True for a pointer that names a real slot
  function automatic logic is_slot(input ptr_t p);
    return p < PTR_W'(NUM_SLOTS);
  endfunction

endpackage

// File: design/mqsb_link_mgr.sv
// ----------------------------------------------------------------------------
// mqsb_link_mgr: queue and free list pointer manager
// Holds the slot links, the head and tail of every queue and the free list
// head. Serves one enqueue or dequeue per cycle and reports the slot used.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_defines.svh"

module mqsb_link_mgr (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  input  mqsb_pkg::req_t  op_req,
  input  mqsb_pkg::qid_t  op_qid,
  output mqsb_pkg::op_res_t res
);
  import mqsb_pkg::*;

  ptr_t slot_link  [NUM_SLOTS];
  ptr_t queue_head [NUM_QUEUES];
  ptr_t queue_tail [NUM_QUEUES];
  ptr_t free_head;

  ptr_t  head;
  ptr_t  tail;
  ptr_t  rd_ptr;
  ptr_t  nx;
  ptr_t  nx_clean;
  logic  enq_ok;
  logic  deq_ok;

  // Look up the queue and the link behind the slot being taken
  always_comb begin
    head     = queue_head[op_qid];
    tail     = queue_tail[op_qid];
    rd_ptr   = (op_req == REQ_ENQ) ? free_head : head;
    nx       = slot_link[rd_ptr[SLOT_W-1:0]];
    nx_clean = is_slot(nx) ? nx : NULL_PTR;
    enq_ok   = op_valid && (op_req == REQ_ENQ) && is_slot(free_head);
    deq_ok   = op_valid && (op_req == REQ_DEQ) && is_slot(head);
  end

  // Report the outcome to the data side
  always_comb begin
    res.slot    = rd_ptr[SLOT_W-1:0];
    res.data_we = enq_ok;
    res.data_rd = deq_ok;
    if (op_req == REQ_ENQ) begin
      res.status = is_slot(free_head) ? STATUS_OK : STATUS_FULL;
    end else begin
      res.status = is_slot(head) ? STATUS_OK : STATUS_EMPTY;
    end
  end

  // Relink slots and advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_link[i] <= PTR_W'(i + 1);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_head[i] <= NULL_PTR;
        queue_tail[i] <= NULL_PTR;
      end
      free_head <= '0;
    end else if (enq_ok) begin
      free_head <= nx_clean;
      if (!is_slot(head)) begin
        queue_head[op_qid] <= free_head;
      end else if (is_slot(tail)) begin
        slot_link[tail[SLOT_W-1:0]] <= free_head;
      end
      slot_link[free_head[SLOT_W-1:0]] <= NULL_PTR;
      queue_tail[op_qid] <= free_head;
    end else if (deq_ok) begin
      queue_head[op_qid] <= nx_clean;
      slot_link[head[SLOT_W-1:0]] <= free_head;
      free_head <= head;
    end
  end

  // Pointer bookkeeping checks
  `MQSB_ASSERT_NEXT(a_enq_sets_tail, enq_ok, queue_tail[$past(op_qid)] == $past(free_head), "enqueue did not move the tail to the taken slot")
  `MQSB_ASSERT_NEXT(a_deq_frees_head, deq_ok, free_head == $past(head), "dequeue did not return the head slot to the free list")
  `MQSB_ASSERT_SAME(a_free_head_range, 1'b1, free_head <= NULL_PTR, "free list head out of range")

endmodule

// File: design/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several FIFO queues in one linked slot store
// Enqueue takes a slot from the free list and links it after the queue tail;
// dequeue unlinks the queue head and returns it to the free list.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser
//  s_*      in   [1:0] queue_id, [33:2] data   [0] req_type (0 enq, 1 deq)
//  m_*      out  [31:0] data_out               [1:0] status
//
// One item per cycle sustained while m_* is not stalled; the result passes
// through the input register, then pointer update and result register.
// Every request that succeeds updates the links and pointers in the cycle it leaves the
// input register, so the next item sees the new state without a gap.
// Reset restores the link chain and pointers all at once; no clearing pass.
// A stall on m_* holds the result and the waiting input item in place.
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_defines.svh"

module multi_queue_shared_buffer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mqsb_pkg::S_TDATA_W-1:0] s_tdata,   // queue_id, data_in, zero pad
  input  logic                           s_tuser,   // req_type
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [mqsb_pkg::M_TDATA_W-1:0] m_tdata,   // data_out
  output logic [1:0]                     m_tuser    // status
);
  import mqsb_pkg::*;

  // Input register
  logic                  in_valid;
  req_t                  in_req;
  logic [QUEUE_ID_W-1:0] in_qid;
  logic [DATA_W-1:0]     in_data;

  // Result register
  logic                  out_valid;
  logic [DATA_W-1:0]     data_out;
  status_t               status;

  logic [DATA_W-1:0]     slot_data [NUM_SLOTS];
  logic                  advance;
  logic                  proc;
  op_res_t               res;

  assign advance  = !out_valid || m_tready;
  assign proc     = in_valid && advance;
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = data_out;
  assign m_tuser  = status;

  // Capture the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req  <= req_t'(s_tuser);
      in_qid  <= s_tdata[QUEUE_ID_W-1:0];
      in_data <= s_tdata[QUEUE_ID_W +: DATA_W];
    end
  end

  mqsb_link_mgr u_link_mgr (
    .clk      (clk),
    .rst      (rst),
    .op_valid (proc),
    .op_req   (in_req),
    .op_qid   (in_qid[QID_W-1:0]),
    .res      (res)
  );

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  // Slot store: write on enqueue, read into the result on dequeue
  always_ff @(posedge clk) begin
    if (res.data_we) begin
      slot_data[res.slot] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      status   <= res.status;
      data_out <= res.data_rd ? slot_data[res.slot] : '0;
    end
  end

  // Datapath checks
  `MQSB_ASSERT_SAME(a_ready_only_on_stall, !s_tready, in_valid && out_valid && !m_tready, "input blocked without a stalled result")
  `MQSB_ASSERT_SAME(a_error_zero_data, out_valid && status != STATUS_OK, data_out == '0, "error result carries data")
  `MQSB_ASSERT_NEXT(a_enq_zero_data, proc && in_req == REQ_ENQ, out_valid && data_out == '0, "enqueue result not zero")

endmodule

// File: tb/multi_queue_shared_buffer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_tb: self-checking bench for the shared-store queues
// Drives enqueue and dequeue requests into the stream input, tracks the linked
// slot store and free list in a software copy, and compares every returned
// item against the predicted value and status in order.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer_tb;
  import mqsb_pkg::*;

  localparam int LONG_STALL   = 300;
  localparam int STALL_AT     = 330;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int DRAIN_CYCLES = 8;

  // Expected reply for one request
  typedef struct packed {
    logic [DATA_W-1:0] data;
    status_t           status;
  } reply_t;

  // Software copy of the slot store, the queue pointers and the free list
  class queue_tracker;
    logic [DATA_W-1:0] store [NUM_SLOTS];
    ptr_t              links [NUM_SLOTS];
    ptr_t              heads [NUM_QUEUES];
    ptr_t              tails [NUM_QUEUES];
    ptr_t              free_head;
    reply_t            pending_replies[$];
    int unsigned       accepted;
    int unsigned       errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        store[i] = '0;
        links[i] = (i == NUM_SLOTS - 1) ? NULL_PTR : ptr_t'(i + 1);
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads[i] = NULL_PTR;
        tails[i] = NULL_PTR;
      end
      free_head = '0;
      accepted  = 0;
      errors    = 0;
    endfunction

    // Apply one accepted request and queue the reply it must produce
    function void note_request(req_t kind, logic [1:0] qid, logic [DATA_W-1:0] value);
      reply_t r;
      ptr_t   slot;
      ptr_t   nx;
      int     q;
      q = int'(qid) % NUM_QUEUES;
      r.data   = '0;
      r.status = STATUS_OK;
      if (kind == REQ_ENQ) begin
        slot = free_head;
        if (slot >= NUM_SLOTS) begin
          r.status = STATUS_FULL;
        end else begin
          nx = links[slot];
          free_head = (nx < NUM_SLOTS) ? nx : NULL_PTR;
          // An empty queue takes the slot as head; the stale tail is ignored
          if (heads[q] >= NUM_SLOTS) begin
            heads[q] = slot;
          end else if (tails[q] < NUM_SLOTS) begin
            links[tails[q]] = slot;
          end
          links[slot] = NULL_PTR;
          tails[q]    = slot;
          store[slot] = value;
        end
      end else begin
        slot = heads[q];
        if (slot >= NUM_SLOTS) begin
          r.status = STATUS_EMPTY;
        end else begin
          nx = links[slot];
          heads[q]    = (nx < NUM_SLOTS) ? nx : NULL_PTR;
          links[slot] = free_head;
          free_head   = slot;
          r.data      = store[slot];
        end
      end
      pending_replies.push_back(r);
      accepted++;
    endfunction

    // Compare one returned item with the oldest expected reply
    function void check_result(logic [DATA_W-1:0] data, logic [1:0] status);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $error("unexpected item: data_out %h status %0d", data, status);
        errors++;
        return;
      end
      r = pending_replies.pop_front();
      if (data !== r.data) begin
        $error("data_out: expected %h, actual %h", r.data, data);
        errors++;
      end
      if (status !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, status);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [1:0]           m_tuser;

  queue_tracker tracker;
  bit           quiet;
  bit           long_stall_done;

  multi_queue_shared_buffer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until accepted, then idle for a random gap
  task automatic send_item(req_t kind, logic [1:0] qid, logic [DATA_W-1:0] value);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W - DATA_W - QUEUE_ID_W){1'b0}}, value, qid};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(kind, qid, value);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random value with the extremes mixed in now and then
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random back-pressure plus one long hold-off to fill the block
  initial begin : receiver
    int unsigned stall;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (!long_stall_done && tracker.accepted >= STALL_AT) begin
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end
      stall = pick_gap();
      if (stall == 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every returned item
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      tracker.check_result(m_tdata, m_tuser);
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int unsigned enq_pct;
    int unsigned fav_q;
    logic [1:0]  qid;
    tracker         = new();
    quiet           = 1'b0;
    long_stall_done = 1'b0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tuser  <= REQ_ENQ;
    s_tdata  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Dequeue from an empty queue
    send_item(REQ_DEQ, 2'd0, 32'h1234_5678);
    // Extreme values, one per queue
    send_item(REQ_ENQ, 2'd0, 32'h0000_0000);
    send_item(REQ_ENQ, 2'd1, 32'hFFFF_FFFF);
    send_item(REQ_ENQ, 2'd2, 32'h8000_0000);
    send_item(REQ_ENQ, 2'd3, 32'h7FFF_FFFF);
    // Use up the rest of the store, then one enqueue too many
    repeat (NUM_SLOTS - NUM_QUEUES) send_item(REQ_ENQ, 2'd1, $urandom());
    send_item(REQ_ENQ, 2'd2, 32'hDEAD_BEEF);
    // Drain queue 0, dequeue it empty, refill past the stale tail
    send_item(REQ_DEQ, 2'd0, 32'h0);
    send_item(REQ_DEQ, 2'd0, 32'h0);
    send_item(REQ_ENQ, 2'd0, 32'h5555_AAAA);
    send_item(REQ_DEQ, 2'd0, 32'hFFFF_FFFF);
    send_item(REQ_DEQ, 2'd2, 32'h0);
    send_item(REQ_DEQ, 2'd3, 32'h0);

    // Random phases that swing the store between full and empty
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 3)
        0:       enq_pct = 85;
        1:       enq_pct = 20;
        default: enq_pct = 50;
      endcase
      quiet = (p == 3 || p == 6);
      fav_q = $urandom_range(0, NUM_QUEUES - 1);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        qid = ($urandom_range(0, 1) == 0) ? 2'(fav_q) : 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < enq_pct) begin
          send_item(REQ_ENQ, qid, pick_value());
        end else begin
          send_item(REQ_DEQ, qid, $urandom());
        end
      end
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;

    // Wait for outstanding replies, then let the pipeline settle
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/mqsb_pkg.sv
design/mqsb_link_mgr.sv
design/multi_queue_shared_buffer.sv
tb/multi_queue_shared_buffer_tb.sv
